// ===== rtl/core/kpc_pkg.sv =====
// Package for the key press classifier: word types, register indexes, timing constants.
package kpc_pkg;

    // Width of the internal millisecond time base (legal range 13..16)
    localparam int TIME_WIDTH = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_TYPE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID      = 3'd5;

    // Timing constants in ms
    localparam int DEBOUNCE_MS  = 50;
    localparam int REPEAT_MS    = 300;
    localparam int SWITCH_MS    = 100;
    localparam int LONG_UNIT_MS = 100;

    // Long time limits in 100 ms units
    localparam logic [5:0] LONG_MIN     = 6'd4;
    localparam logic [5:0] LONG_MAX     = 6'd50;
    localparam logic [5:0] LONG_DEFAULT = 6'd10;

    // Input type codes
    localparam logic TYPE_PUSH   = 1'b0;
    localparam logic TYPE_SWITCH = 1'b1;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Input word
    typedef struct packed {
        logic        pin_level;
        logic [15:0] now_ms;
        logic        bus_ready;
    } t_kpc_in;

    // Result word
    typedef struct packed {
        logic       event_valid;
        logic       event_long;
        logic [7:0] event_count;
        logic [7:0] event_channel;
        logic       feedback_valid;
        logic       feedback_on;
    } t_kpc_out;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic       enable;
        logic       input_type;
        logic [5:0] long_time;
        logic       feedback_enable;
        logic       active_low;
        logic [7:0] channel_id;
    } t_kpc_cfg;

    // Per-channel key state
    typedef struct packed {
        logic       press_active;
        t_time      press_start;
        logic       long_active;
        t_time      long_start;
        logic [7:0] press_number;
    } t_kpc_state;

endpackage

// ===== rtl/core/kpc_cfg.sv =====
// Configuration register file with long time range check and channel clear strobe.
module kpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output kpc_pkg::t_kpc_cfg              o_cfg,
    output logic                           o_clear
);
    import kpc_pkg::*;

    t_kpc_cfg   r_cfg;
    t_kpc_cfg   n_cfg;
    logic [5:0] w_long;

    // Out-of-range long time falls back to the default
    always_comb begin
        w_long = i_cfg_data[5:0];
        if (w_long < LONG_MIN || w_long > LONG_MAX) begin
            w_long = LONG_DEFAULT;
        end
    end

    // Register decode
    always_comb begin
        n_cfg   = r_cfg;
        o_clear = 1'b0;
        if (i_cfg_we) begin
            o_clear = 1'b1;
            case (i_cfg_idx)
                CFG_ENABLE:          n_cfg.enable          = i_cfg_data[0];
                CFG_INPUT_TYPE:      n_cfg.input_type      = i_cfg_data[0];
                CFG_LONG_TIME:       n_cfg.long_time       = w_long;
                CFG_FEEDBACK_ENABLE: n_cfg.feedback_enable = i_cfg_data[0];
                CFG_ACTIVE_LOW:      n_cfg.active_low      = i_cfg_data[0];
                CFG_CHANNEL_ID:      n_cfg.channel_id      = i_cfg_data[7:0];
                default:             o_clear               = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b1;
            r_cfg.input_type      <= TYPE_PUSH;
            r_cfg.long_time       <= LONG_DEFAULT;
            r_cfg.feedback_enable <= 1'b0;
            r_cfg.active_low      <= 1'b1;
            r_cfg.channel_id      <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/kpc_step.sv =====
// One classification step: key state, config and input word to next state and result word.
module kpc_step (
    input  kpc_pkg::t_kpc_cfg   i_cfg,
    input  kpc_pkg::t_kpc_state i_state,
    input  kpc_pkg::t_kpc_in    i_word,
    output kpc_pkg::t_kpc_state o_state,
    output kpc_pkg::t_kpc_out   o_word
);
    import kpc_pkg::*;

    t_time      w_now;
    t_time      w_press_el;
    t_time      w_long_el;
    t_time      w_long_thr;
    logic       w_pressed;
    logic       w_ev;
    logic       w_ev_long;
    logic [7:0] w_ev_count;
    logic       w_fb;
    logic       w_fb_on;
    logic [7:0] w_num_inc;

    // Elapsed times wrap with the time base
    assign w_now      = TIME_WIDTH'(i_word.now_ms);
    assign w_press_el = w_now - i_state.press_start;
    assign w_long_el  = w_now - i_state.long_start;
    assign w_long_thr = TIME_WIDTH'(i_cfg.long_time) * TIME_WIDTH'(LONG_UNIT_MS);
    assign w_pressed  = i_cfg.active_low ? !i_word.pin_level : i_word.pin_level;
    assign w_num_inc  = i_state.press_number + 8'd1;

    always_comb begin
        o_state    = i_state;
        w_ev       = 1'b0;
        w_ev_long  = 1'b0;
        w_ev_count = 8'd0;
        w_fb       = 1'b0;
        w_fb_on    = 1'b0;
        if (i_cfg.enable) begin
            if (i_cfg.input_type == TYPE_PUSH) begin
                // Push button: short on release, long and repeats while held
                if (!w_pressed) begin
                    if (i_state.press_active) begin
                        if (w_press_el >= TIME_WIDTH'(DEBOUNCE_MS) && !i_state.long_active) begin
                            o_state.press_number = w_num_inc;
                            w_ev       = 1'b1;
                            w_ev_count = w_num_inc;
                        end
                        o_state.press_active = 1'b0;
                        w_fb = 1'b1;
                    end
                end else if (i_state.press_active) begin
                    if (i_state.long_active) begin
                        if (w_long_el >= TIME_WIDTH'(REPEAT_MS)) begin
                            o_state.long_start = w_now;
                            w_ev       = 1'b1;
                            w_ev_long  = 1'b1;
                            w_ev_count = i_state.press_number;
                        end
                    end else if (w_press_el >= w_long_thr) begin
                        o_state.press_number = w_num_inc;
                        o_state.long_active  = 1'b1;
                        o_state.long_start   = w_now;
                        w_ev       = 1'b1;
                        w_ev_long  = 1'b1;
                        w_ev_count = w_num_inc;
                    end
                end else begin
                    o_state.press_active = 1'b1;
                    o_state.press_start  = w_now;
                    o_state.long_active  = 1'b0;
                    w_fb    = 1'b1;
                    w_fb_on = 1'b1;
                end
            end else begin
                // Switch: each edge reported, held until the bus takes it
                if (!w_pressed) begin
                    if (i_state.long_active && i_word.bus_ready) begin
                        w_ev       = 1'b1;
                        w_ev_count = i_state.press_number;
                        o_state.press_number = w_num_inc;
                        o_state.long_active  = 1'b0;
                    end
                    o_state.press_active = 1'b0;
                    w_fb = 1'b1;
                end else begin
                    if (!i_state.press_active) begin
                        o_state.press_active = 1'b1;
                        o_state.press_start  = w_now;
                    end else if (w_press_el >= TIME_WIDTH'(SWITCH_MS) && !i_state.long_active
                                 && i_word.bus_ready) begin
                        w_ev       = 1'b1;
                        w_ev_count = i_state.press_number;
                        o_state.press_number = w_num_inc;
                        o_state.long_active  = 1'b1;
                        o_state.long_start   = w_now;
                    end
                    w_fb    = 1'b1;
                    w_fb_on = 1'b1;
                end
            end
            if (!i_cfg.feedback_enable) begin
                w_fb    = 1'b0;
                w_fb_on = 1'b0;
            end
        end
    end

    // Result word; fields read zero when their flag is clear
    always_comb begin
        o_word.event_valid    = w_ev;
        o_word.event_long     = w_ev && w_ev_long;
        o_word.event_count    = w_ev ? w_ev_count : 8'd0;
        o_word.event_channel  = w_ev ? i_cfg.channel_id : 8'd0;
        o_word.feedback_valid = w_fb;
        o_word.feedback_on    = w_fb && w_fb_on;
    end

endmodule

// ===== rtl/core/key_press_classifier_core.sv =====
// Top level: input register, key state, classification step and result register.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_in_word  (pin, time, bus)
//  out     | source    | o_out_valid / i_out_stall  | o_out_word (event, feedback)
//  cfg     | sink      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the result is not stalled; each word gives one result word.
// A word passes through the input register, the step logic and then the result register.
// Reset is synchronous: registers return to 1,0,10,0,1,0 and the key state clears.
// A stalled result holds; the input register still takes one more word behind it.
// A write to any defined register (index 0 to 5) clears the key state and press number.
module key_press_classifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  kpc_pkg::t_kpc_in               i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output kpc_pkg::t_kpc_out              o_out_word,
    input  logic                           i_cfg_we,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kpc_pkg::*;

    t_kpc_cfg   w_cfg;
    logic       w_clear;
    t_kpc_state r_state;
    t_kpc_state n_state;
    t_kpc_out   n_out;
    logic       r_in_valid;
    t_kpc_in    r_in;
    logic       r_out_valid;
    t_kpc_out   r_out;
    logic       w_out_free;
    logic       w_adv;
    logic       w_in_acc;

    kpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_clear    (w_clear)
    );

    kpc_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_word  (r_in),
        .o_state (n_state),
        .o_word  (n_out)
    );

    // Pipeline handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in <= i_in_word;
        end
    end

    // Key state, updated as each word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A register write leaves the channel cleared
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_state.press_number == 8'd0 && !r_state.press_active
                     && !r_state.long_active))
        else $error("key state not cleared after register write");

    // Key state moves only with a word or a register write
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && !w_clear) |=> $stable(r_state))
        else $error("key state changed without a word");

    // A word leaving the input register shows up as a result
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result lost after step");

    // Input stalls only while a word waits behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

endmodule
